>>> rtl/wspt_pkg.sv
package wspt_pkg;

    // Q16.16 constants
    localparam logic [16:0] ONE_Q16       = 17'd65536;
    localparam logic [13:0] C_POINT_TWO   = 14'd13107;
    localparam logic [15:0] C_POINT_EIGHT = 16'd52429;
    localparam logic [10:0] C_INT_LIMIT   = 11'd1638;
    localparam logic [12:0] C_POINT_ONE   = 13'd6554;

    // item modes
    localparam logic MODE_TELEMETRY = 1'b0;
    localparam logic MODE_COMMAND   = 1'b1;

    // shared divider geometry: quotient is known to fit in DIV_Q_W bits
    localparam int DIV_NUM_W = 50;
    localparam int DIV_DEN_W = 47;
    localparam int DIV_Q_W   = 34;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KI_DT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RATED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_V  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_FLOOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ERPM   = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_WS,
        ST_T_SQ,
        ST_T_DST,
        ST_T_DWAIT,
        ST_T_MIX,
        ST_C_ERR,
        ST_C_INT,
        ST_C_SUM,
        ST_C_WAIT,
        ST_C_DUTY,
        ST_C_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic tel_ws;
        logic tel_sq;
        logic tel_div;
        logic tel_mix;
        logic cmd_err;
        logic cmd_int;
        logic cmd_sum;
        logic cmd_duty;
        logic cmd_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } dp_stat_t;

endpackage

>>> rtl/wspt_div.sv
module wspt_div
    import wspt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic [DIV_Q_W-1:0]   quo
);

    localparam int CNT_W = $clog2(DIV_Q_W + 1);
    localparam int PRE_W = DIV_NUM_W - DIV_Q_W;

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_Q_W-1:0]   bits_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    // one restoring step: quotient bit shifts in where numerator bit shifts out
    always_comb
    begin
        trial = {rem_reg, bits_reg[DIV_Q_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_Q_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // top numerator bits are below den (den >= 1.0), so they preload the remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {{(DIV_DEN_W-PRE_W){1'b0}}, num[DIV_NUM_W-1:DIV_Q_W]};
            bits_reg <= num[DIV_Q_W-1:0];
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            bits_reg <= {bits_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = bits_reg;

endmodule

>>> rtl/wspt_dp.sv
module wspt_dp
    import wspt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic signed [20:0]   erpm_count,
    input  logic [30:0]          supply_voltage,
    input  logic signed [17:0]   applied_duty,
    input  logic signed [31:0]   motor_current,
    input  logic signed [31:0]   speed_target,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [30:0]          duty_value,
    output logic [16:0]          drag_estimate
);

    // saturate a sign/magnitude value to signed 32 bits
    function automatic logic signed [31:0] sat_sm(input logic neg, input logic [47:0] m);
        if (!neg)
        begin
            return (m > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
        end
        else
        begin
            return (m > 48'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
        end
    endfunction

    // configuration
    logic [30:0]        ki_reg;
    logic [30:0]        inv_rated_reg;
    logic [30:0]        nominal_reg;
    logic [30:0]        floor_reg;
    logic [30:0]        step_reg;
    logic signed [31:0] inv_erpm_reg;

    // captured item
    logic signed [20:0] erpm_reg;
    logic [30:0]        supply_in_reg;
    logic signed [17:0] duty_in_reg;
    logic signed [31:0] cur_reg;
    logic signed [31:0] target_reg;

    // loop state
    logic signed [31:0] ws_reg;
    logic [30:0]        supply_reg;
    logic [16:0]        drag_reg;
    logic signed [11:0] integ_reg;
    logic [30:0]        last_reg;

    // intermediates
    logic [33:0]        power_reg;
    logic [46:0]        sq_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] ratio_reg;
    logic signed [34:0] ff_reg;
    logic signed [31:0] inner_reg;
    logic [30:0]        duty_reg;

    // output register
    logic               out_valid_reg;
    logic [30:0]        throttle_reg;
    logic [16:0]        drag_out_reg;

    // divider
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy;
    logic [DIV_Q_W-1:0]   div_quo;

    // telemetry products
    logic [52:0]        ws_prod;
    logic signed [31:0] ws_next;
    logic [17:0]        mag_duty;
    logic [31:0]        mag_cur;
    logic [49:0]        pow_prod;
    logic [31:0]        mag_ws;
    logic [63:0]        sq_prod;
    logic [49:0]        mix_sum;
    logic [33:0]        mix;
    logic [16:0]        drag_next;

    // command products
    logic signed [32:0] diff;
    logic [32:0]        mag_diff;
    logic [63:0]        err_prod;
    logic [31:0]        mag_tgt;
    logic [62:0]        ratio_prod;
    logic [31:0]        mag_err;
    logic [62:0]        ki_prod;
    logic signed [47:0] ki_term;
    logic signed [48:0] integ_sum;
    logic signed [11:0] integ_next;
    logic [43:0]        floor_prod;
    logic [17:0]        ff_gain;
    logic [31:0]        mag_ratio;
    logic [49:0]        ff_prod;
    logic signed [36:0] inner_sum;
    logic signed [31:0] inner_next;
    logic [61:0]        duty_prod;
    logic [30:0]        duty_next;
    logic signed [32:0] slew_lo;
    logic [31:0]        slew_hi;
    logic [30:0]        slew_a;
    logic [30:0]        slew_d;

    wspt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // telemetry datapath
    always_comb
    begin
        ws_prod = {{32{erpm_reg[20]}}, erpm_reg} * {{21{inv_erpm_reg[31]}}, inv_erpm_reg};
        if ((ws_prod[52:31] == '0) || (ws_prod[52:31] == '1))
        begin
            ws_next = $signed(ws_prod[31:0]);
        end
        else
        begin
            ws_next = ws_prod[52] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        mag_duty = duty_in_reg[17] ? 18'(-duty_in_reg) : 18'(duty_in_reg);
        mag_cur  = cur_reg[31] ? 32'(-cur_reg) : 32'(cur_reg);
        pow_prod = {32'b0, mag_duty} * {18'b0, mag_cur};
        mag_ws   = ws_reg[31] ? 32'(-ws_reg) : 32'(ws_reg);
        sq_prod  = {32'b0, mag_ws} * {32'b0, mag_ws};
        mix_sum  = {16'b0, div_quo} * 50'(C_POINT_TWO)
                 + {33'b0, drag_reg} * 50'(C_POINT_EIGHT);
        mix      = mix_sum[49:16];
        drag_next = (mix > 34'(ONE_Q16)) ? ONE_Q16 : mix[16:0];
    end

    // command datapath
    always_comb
    begin
        diff       = {target_reg[31], target_reg} - {ws_reg[31], ws_reg};
        mag_diff   = diff[32] ? 33'(-diff) : 33'(diff);
        err_prod   = {31'b0, mag_diff} * {33'b0, inv_rated_reg};
        mag_tgt    = target_reg[31] ? 32'(-target_reg) : 32'(target_reg);
        ratio_prod = {31'b0, mag_tgt} * {32'b0, inv_rated_reg};

        mag_err    = err_reg[31] ? 32'(-err_reg) : 32'(err_reg);
        ki_prod    = {31'b0, mag_err} * {32'b0, ki_reg};
        ki_term    = err_reg[31] ? -$signed({1'b0, ki_prod[62:16]})
                                 : $signed({1'b0, ki_prod[62:16]});
        integ_sum  = 49'(integ_reg) + 49'(ki_term);
        floor_prod = {13'b0, floor_reg} * {31'b0, C_POINT_ONE};
        if (target_reg < $signed({4'b0, floor_prod[43:16]}))
        begin
            integ_next = '0;
        end
        else if (integ_sum > $signed({38'b0, C_INT_LIMIT}))
        begin
            integ_next = $signed({1'b0, C_INT_LIMIT});
        end
        else if (integ_sum < -$signed({38'b0, C_INT_LIMIT}))
        begin
            integ_next = -$signed({1'b0, C_INT_LIMIT});
        end
        else
        begin
            integ_next = integ_sum[11:0];
        end

        ff_gain   = 18'(ONE_Q16) + {1'b0, drag_reg};
        mag_ratio = ratio_reg[31] ? 32'(-ratio_reg) : 32'(ratio_reg);
        ff_prod   = {32'b0, ff_gain} * {18'b0, mag_ratio};

        inner_sum = 37'(ff_reg) + 37'(err_reg) + 37'(integ_reg);
        if ((inner_sum[36:31] == '0) || (inner_sum[36:31] == '1))
        begin
            inner_next = inner_sum[31:0];
        end
        else
        begin
            inner_next = inner_sum[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end

        duty_prod = {31'b0, div_quo[30:0]} * {31'b0, inner_reg[30:0]};
        if (inner_reg[31] || (inner_reg == '0))
        begin
            duty_next = '0;
        end
        else if (duty_prod[61:16] > 46'h7FFF_FFFF)
        begin
            duty_next = 31'h7FFF_FFFF;
        end
        else
        begin
            duty_next = duty_prod[46:16];
        end

        // slew window around the last duty
        slew_lo = $signed({2'b0, last_reg}) - $signed({2'b0, step_reg});
        slew_hi = {1'b0, last_reg} + {1'b0, step_reg};
        slew_a  = (slew_lo > $signed({2'b0, duty_reg})) ? slew_lo[30:0] : duty_reg;
        slew_d  = ({1'b0, slew_a} > slew_hi) ? slew_hi[30:0] : slew_a;
    end

    // divider operands: drag measurement or voltage gain
    always_comb
    begin
        div_start = cmd.tel_div | cmd.cmd_err;
        if (cmd.cmd_err)
        begin
            div_num = {3'b0, nominal_reg, 16'b0};
            div_den = {16'b0, (supply_reg > 31'(ONE_Q16)) ? supply_reg : 31'(ONE_Q16)};
        end
        else
        begin
            div_num = {power_reg, 16'b0};
            div_den = (sq_reg > 47'(ONE_Q16)) ? sq_reg : 47'(ONE_Q16);
        end
    end

    // configuration registers and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ki_reg        <= '0;
            inv_rated_reg <= 31'(ONE_Q16);
            nominal_reg   <= 31'd786432;
            floor_reg     <= '0;
            step_reg      <= 31'(ONE_Q16);
            inv_erpm_reg  <= 32'sd65536;
            ws_reg        <= '0;
            supply_reg    <= '0;
            drag_reg      <= '0;
            integ_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KI_DT:      ki_reg        <= cfg_data[30:0];
                    REG_INV_RATED:  inv_rated_reg <= cfg_data[30:0];
                    REG_NOMINAL_V:  nominal_reg   <= cfg_data[30:0];
                    REG_INT_FLOOR:  floor_reg     <= cfg_data[30:0];
                    REG_STEP_LIMIT: step_reg      <= cfg_data[30:0];
                    REG_INV_ERPM:   inv_erpm_reg  <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.tel_ws)
            begin
                ws_reg     <= ws_next;
                supply_reg <= supply_in_reg;
            end
            if (cmd.tel_mix)
            begin
                drag_reg <= drag_next;
            end
            if (cmd.cmd_int)
            begin
                integ_reg <= integ_next;
            end
            if (cmd.cmd_out)
            begin
                last_reg      <= slew_d;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, intermediate and output data registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            erpm_reg      <= erpm_count;
            supply_in_reg <= supply_voltage;
            duty_in_reg   <= applied_duty;
            cur_reg       <= motor_current;
            target_reg    <= speed_target;
        end
        if (cmd.tel_ws)
        begin
            power_reg <= pow_prod[49:16];
        end
        if (cmd.tel_sq)
        begin
            sq_reg <= sq_prod[62:16];
        end
        if (cmd.cmd_err)
        begin
            err_reg   <= sat_sm(diff[32], err_prod[63:16]);
            ratio_reg <= sat_sm(target_reg[31], {1'b0, ratio_prod[62:16]});
        end
        if (cmd.cmd_int)
        begin
            ff_reg <= ff_prod[49:16] == '0 ? 35'sd0
                    : (ratio_reg[31] ? -$signed({1'b0, ff_prod[49:16]})
                                     : $signed({1'b0, ff_prod[49:16]}));
        end
        if (cmd.cmd_sum)
        begin
            inner_reg <= inner_next;
        end
        if (cmd.cmd_duty)
        begin
            duty_reg <= duty_next;
        end
        if (cmd.cmd_out)
        begin
            throttle_reg <= slew_d;
            drag_out_reg <= drag_reg;
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.out_full = out_valid_reg & out_stall;
    assign out_valid     = out_valid_reg;
    assign duty_value    = throttle_reg;
    assign drag_estimate = drag_out_reg;

    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= $signed({1'b0, C_INT_LIMIT})) && (integ_reg >= -$signed({1'b0, C_INT_LIMIT})))
        else $error("integral left its clamp window");

    a_drag_range: assert property (@(posedge clk) disable iff (!rst_n)
        drag_reg <= ONE_Q16)
        else $error("drag estimate above 1.0");

    a_out_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmd_out |=> (out_valid_reg && (throttle_reg == last_reg)))
        else $error("emitted duty differs from stored last duty");

endmodule

>>> rtl/wspt_ctrl.sv
module wspt_ctrl
    import wspt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     mode,
    input  dp_stat_t stat,
    output logic     in_stall,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencing of datapath steps
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (mode == MODE_COMMAND) ? ST_C_ERR : ST_T_WS;
                end
            end
            ST_T_WS:
            begin
                cmd.tel_ws = 1'b1;
                state_next = ST_T_SQ;
            end
            ST_T_SQ:
            begin
                cmd.tel_sq = 1'b1;
                state_next = ST_T_DST;
            end
            ST_T_DST:
            begin
                cmd.tel_div = 1'b1;
                state_next  = ST_T_DWAIT;
            end
            ST_T_DWAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_T_MIX;
                end
            end
            ST_T_MIX:
            begin
                cmd.tel_mix = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_C_ERR:
            begin
                cmd.cmd_err = 1'b1;
                state_next  = ST_C_INT;
            end
            ST_C_INT:
            begin
                cmd.cmd_int = 1'b1;
                state_next  = ST_C_SUM;
            end
            ST_C_SUM:
            begin
                cmd.cmd_sum = 1'b1;
                state_next  = ST_C_WAIT;
            end
            ST_C_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_C_DUTY;
                end
            end
            ST_C_DUTY:
            begin
                cmd.cmd_duty = 1'b1;
                state_next   = ST_C_OUT;
            end
            ST_C_OUT:
            begin
                if (!stat.out_full)
                begin
                    cmd.cmd_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_C_WAIT && stat.div_busy) |=> (state_reg == ST_C_WAIT))
        else $error("left divider wait while divider busy");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmd_out |-> !stat.out_full)
        else $error("result written over an unaccepted item");

    a_capture_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (in_valid && !in_stall))
        else $error("item captured without an accept");

endmodule

>>> rtl/wheel_speed_pi_throttle_top.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  mode, erpm_count, supply_voltage,
//                                           applied_duty, motor_current, speed_target
// output    out        out_valid/out_stall  duty_value, drag_estimate
// config    in         cfg_we               cfg_index, cfg_data
//
// Telemetry item: speed/power, square, a 34-step restoring divide, then the drag mix.
// Command item: error and divide start, integral, sum, divider wait, duty, output.
// One item is in work at a time; in_stall is high until the item finishes.
// A finished result sits in the output register; the next item is accepted
// while it waits, and a command only stalls at its end if that register is full.
// Reset (rst_n, async, low) clears loop state and loads register defaults.
module wheel_speed_pi_throttle_top
    import wspt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  logic signed [20:0]   erpm_count,
    input  logic [30:0]          supply_voltage,
    input  logic signed [17:0]   applied_duty,
    input  logic signed [31:0]   motor_current,
    input  logic signed [31:0]   speed_target,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [30:0]          duty_value,
    output logic [16:0]          drag_estimate,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    wspt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    wspt_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .erpm_count     (erpm_count),
        .supply_voltage (supply_voltage),
        .applied_duty   (applied_duty),
        .motor_current  (motor_current),
        .speed_target   (speed_target),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .duty_value     (duty_value),
        .drag_estimate  (drag_estimate)
    );

endmodule
